@@ hw/rtl/salsc_pkg.sv @@
// Types and constants shared by the cache tag and state store.
`timescale 1ns / 1ps

package salsc_pkg;

  localparam int CFG_AW = 4;
  localparam int RANK_W = 4;

  localparam logic [2:0] ACT_LOOKUP = 3'd0;
  localparam logic [2:0] ACT_TOUCH  = 3'd1;
  localparam logic [2:0] ACT_INSERT = 3'd2;
  localparam logic [2:0] ACT_UPDATE = 3'd3;
  localparam logic [2:0] ACT_REMOVE = 3'd4;

  localparam logic [2:0] ST_I  = 3'd0;
  localparam logic [2:0] ST_M  = 3'd3;
  localparam logic [2:0] ST_O  = 3'd4;
  localparam logic [2:0] ST_SM = 3'd6;

  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_ABSENT = 2'd1;
  localparam logic [1:0] STS_FULL   = 2'd2;

  localparam logic [1:0] REG_BOB = 2'd0;
  localparam logic [1:0] REG_SIB = 2'd1;
  localparam logic [1:0] REG_WIU = 2'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] address;
    logic [2:0]  new_state;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [2:0]  line_state;
    logic        needs_eviction;
    logic        needs_writeback;
    logic [31:0] victim_address;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  state;
    logic [31:0] addr;
  } line_t;

  typedef struct packed {
    logic clear;
    logic en;
  } scan_ctl_t;

  typedef struct packed {
    logic              hit;
    logic [2:0]        hit_state;
    logic              found;
    logic [RANK_W-1:0] rank;
  } scan_res_t;

endpackage

@@ hw/rtl/set_assoc_cache_lru_state_store_core.sv @@
// Top level of the cache tag and state store with per-set recency order.
//
//   port group   dir   handshake            beat
//   in_*         in    in_valid / in_stall   in_item_t: action, address, new_state
//   out_*        out   out_valid / out_stall out_item_t: lookup, victim view, status
//   p*           in    psel/penable/pwrite   register write, pready always high
//
// An item passes accept with set read, row capture, one of its n active ways (1 to WAYS)
// per cycle through the shared compare unit, then a step that writes the row back and
// loads the result register.
// After reset a clearing pass writes 2^floor(log2(MAX_SETS)) rows (1024 by
// default), one a cycle, before the first item; register writes are taken meanwhile.
// A waiting result does not block the next accept; the write-back step waits
// while the result register is full and stalled.
`timescale 1ns / 1ps

module set_assoc_cache_lru_state_store_core #(
  parameter int MAX_SETS = 1024,
  parameter int WAYS     = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  salsc_pkg::in_item_t               in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output salsc_pkg::out_item_t              out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [salsc_pkg::CFG_AW-1:0]      paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import salsc_pkg::*;

  localparam int SET_LOG   = $clog2(MAX_SETS + 1) - 1;
  localparam int SET_AW    = (SET_LOG > 0) ? SET_LOG : 1;
  localparam int SET_DEPTH = 1 << SET_LOG;
  localparam int WAY_IW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WAY_CW    = $clog2(WAYS + 1);
  localparam int ROW_W     = WAYS * $bits(line_t);
  localparam logic [3:0] SET_LOG_C = (SET_LOG > 15) ? 4'd15 : 4'(SET_LOG);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_APPLY = 5'b10000
  } fsm_t;

  fsm_t              state_r, state_nxt;
  logic [3:0]        bob_r;
  logic [3:0]        sib_r;
  logic [2:0]        wiu_r;
  logic [SET_AW-1:0] clr_cnt_r;
  logic [WAY_IW-1:0] idx_r;
  logic [WAY_IW-1:0] last_r;
  logic [WAY_CW-1:0] n_r;
  logic              out_valid_r;
  out_item_t         out_data_r;
  in_item_t          item_r;
  logic [SET_AW-1:0] set_r;
  logic [31:0]       mask_r;
  line_t [WAYS-1:0]  row_r;

  logic              accept;
  logic              cfg_we;
  logic              apply_fire;
  logic              clr_last;
  logic [WAY_CW-1:0] n_act;
  logic [3:0]        sib_eff;
  logic [31:0]       blk;
  logic [SET_AW-1:0] set_nxt;
  logic              ram_we;
  logic [SET_AW-1:0] ram_waddr;
  logic [ROW_W-1:0]  ram_wdata;
  logic [ROW_W-1:0]  ram_rdata;
  scan_ctl_t         scan_ctl;
  scan_res_t         scan_res;
  line_t [WAYS-1:0]  new_row;
  logic [1:0]        upd_status;
  line_t             lru_line;

  assign pready     = 1'b1;
  assign cfg_we     = psel && penable && pwrite;
  assign in_stall   = state_r != S_IDLE;
  assign accept     = in_valid && !in_stall;
  assign apply_fire = (state_r == S_APPLY) && (!out_valid_r || !out_stall);
  assign clr_last   = clr_cnt_r == SET_AW'(SET_DEPTH - 1);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign lru_line   = row_r[0];

  always_comb begin
    case (paddr[3:2])
      REG_BOB: prdata = {28'd0, bob_r};
      REG_SIB: prdata = {28'd0, sib_r};
      REG_WIU: prdata = {29'd0, wiu_r};
      default: prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (wiu_r == 3'd0) begin
      n_act = WAY_CW'(1);
    end else if (int'(wiu_r) > WAYS) begin
      n_act = WAY_CW'(WAYS);
    end else begin
      n_act = WAY_CW'(wiu_r);
    end
  end

  assign sib_eff = (sib_r > SET_LOG_C) ? SET_LOG_C : sib_r;
  assign blk     = in_data.address >> bob_r;
  assign set_nxt = blk[SET_AW-1:0] & ~({SET_AW{1'b1}} << sib_eff);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (accept) state_nxt = S_READ;
      S_READ:  state_nxt = S_SCAN;
      S_SCAN:  if (idx_r == last_r) state_nxt = S_APPLY;
      S_APPLY: if (apply_fire) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      bob_r       <= 4'd5;
      sib_r       <= 4'd6;
      wiu_r       <= 3'd2;
      clr_cnt_r   <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (paddr[3:2])
          REG_BOB: bob_r <= pwdata[3:0];
          REG_SIB: sib_r <= pwdata[3:0];
          REG_WIU: wiu_r <= pwdata[2:0];
          default: begin
          end
        endcase
      end
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + SET_AW'(1);
      end
      if (state_r == S_SCAN) begin
        idx_r <= idx_r + WAY_IW'(1);
      end else begin
        idx_r <= '0;
      end
      if (apply_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
      set_r  <= set_nxt;
      mask_r <= 32'hFFFF_FFFF << bob_r;
      n_r    <= n_act;
      last_r <= WAY_IW'(n_act - WAY_CW'(1));
    end
    if (state_r == S_READ) begin
      row_r <= ram_rdata;
    end
    if (apply_fire) begin
      out_data_r.hit             <= scan_res.hit;
      out_data_r.line_state      <= scan_res.hit_state;
      out_data_r.needs_eviction  <= lru_line.state != ST_I;
      out_data_r.needs_writeback <= lru_line.state == ST_M || lru_line.state == ST_SM ||
                                    lru_line.state == ST_O;
      out_data_r.victim_address  <= lru_line.addr;
      out_data_r.status          <= upd_status;
    end
  end

  assign ram_we    = (state_r == S_CLEAR) || apply_fire;
  assign ram_waddr = (state_r == S_CLEAR) ? clr_cnt_r : set_r;
  assign ram_wdata = (state_r == S_CLEAR) ? '0 : new_row;

  salsc_ram #(
    .WIDTH(ROW_W),
    .DEPTH(SET_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(set_nxt),
    .rdata(ram_rdata)
  );

  assign scan_ctl.clear = state_r == S_READ;
  assign scan_ctl.en    = state_r == S_SCAN;

  salsc_scan #(
    .WAYS(WAYS)
  ) u_scan (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (scan_ctl),
    .idx  (idx_r),
    .entry(row_r[idx_r]),
    .addr (item_r.address),
    .mask (mask_r),
    .res  (scan_res)
  );

  salsc_upd #(
    .WAYS(WAYS)
  ) u_upd (
    .row    (row_r),
    .item   (item_r),
    .n_act  (n_r),
    .res    (scan_res),
    .new_row(new_row),
    .status (upd_status)
  );

  a_ram_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR || state_r == S_APPLY))
    else $error("row write outside clear or write-back");

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_READ))
    else $error("accepted beat did not start a set read");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (idx_r <= last_r))
    else $error("scan index past active ways");

  a_full_needs_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == STS_FULL) |-> out_data_r.needs_eviction)
    else $error("insert refused with invalid LRU slot");

endmodule

@@ hw/rtl/salsc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module salsc_ram #(
  parameter int WIDTH = 140,
  parameter int DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/salsc_scan.sv @@
// Shared block compare unit: one way per cycle, first valid and first tag match.
`timescale 1ns / 1ps

module salsc_scan #(
  parameter int WAYS = 4
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  salsc_pkg::scan_ctl_t                     ctl,
  input  logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] idx,
  input  salsc_pkg::line_t                         entry,
  input  logic [31:0]                              addr,
  input  logic [31:0]                              mask,
  output salsc_pkg::scan_res_t                     res
);
  import salsc_pkg::*;

  scan_res_t res_r;
  scan_res_t res_nxt;
  logic      match;

  assign match = ((entry.addr ^ addr) & mask) == 32'd0;

  always_comb begin
    res_nxt = res_r;
    if (ctl.clear) begin
      res_nxt = '0;
    end else if (ctl.en) begin
      if (!res_r.hit && match && entry.state != ST_I) begin
        res_nxt.hit       = 1'b1;
        res_nxt.hit_state = entry.state;
      end
      if (!res_r.found && match) begin
        res_nxt.found = 1'b1;
        res_nxt.rank  = RANK_W'(idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

@@ hw/rtl/salsc_upd.sv @@
// Set row rewrite: reorder ranks and set states for one action.
`timescale 1ns / 1ps

module salsc_upd #(
  parameter int WAYS = 4
) (
  input  salsc_pkg::line_t [WAYS-1:0]   row,
  input  salsc_pkg::in_item_t           item,
  input  logic [$clog2(WAYS+1)-1:0]     n_act,
  input  salsc_pkg::scan_res_t          res,
  output salsc_pkg::line_t [WAYS-1:0]   new_row,
  output logic [1:0]                    status
);
  import salsc_pkg::*;

  localparam int WAY_IW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WAY_CW = $clog2(WAYS + 1);

  logic [WAY_IW-1:0] rk;
  logic [WAY_IW-1:0] nl;
  logic              lru_valid;

  assign rk        = res.rank[WAY_IW-1:0];
  assign nl        = WAY_IW'(n_act - WAY_CW'(1));
  assign lru_valid = row[0].state != ST_I;

  always_comb begin
    new_row = row;
    status  = STS_OK;
    case (item.action)
      ACT_LOOKUP: begin
      end
      ACT_TOUCH: begin
        if (!res.found) begin
          status = STS_ABSENT;
        end else begin
          for (int r = 0; r < WAYS - 1; r++) begin
            if (r >= int'(rk) && r < int'(nl)) begin
              new_row[r] = row[r+1];
            end
          end
          new_row[nl] = row[rk];
        end
      end
      ACT_INSERT: begin
        if (lru_valid) begin
          status = STS_FULL;
        end else begin
          for (int r = 0; r < WAYS - 1; r++) begin
            if (r < int'(nl)) begin
              new_row[r] = row[r+1];
            end
          end
          new_row[nl].state = item.new_state;
          new_row[nl].addr  = item.address;
        end
      end
      ACT_UPDATE: begin
        if (!res.found) begin
          status = STS_ABSENT;
        end else begin
          new_row[rk].state = item.new_state;
        end
      end
      ACT_REMOVE: begin
        if (!res.found) begin
          status = STS_ABSENT;
        end else begin
          for (int r = 1; r < WAYS; r++) begin
            if (r <= int'(rk)) begin
              new_row[r] = row[r-1];
            end
          end
          new_row[0].state = ST_I;
          new_row[0].addr  = row[rk].addr;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ tb/cache_store_checker.sv @@
// Checker for the cache tag and state store: tracks register writes, predicts and compares results.
`timescale 1ns / 1ps

module cache_store_checker #(
  parameter int MAX_SETS = 1024,
  parameter int WAYS     = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  salsc_pkg::in_item_t           in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  salsc_pkg::out_item_t          out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [salsc_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output int                            mismatches,
  output int                            awaiting
);
  import salsc_pkg::*;

  logic [3:0]  offset_cfg;
  logic [3:0]  index_cfg;
  logic [2:0]  ways_cfg;
  logic [2:0]  state_mem [MAX_SETS][WAYS];
  logic [31:0] addr_mem  [MAX_SETS][WAYS];

  out_item_t   due_results [$];
  out_item_t   predicted;
  out_item_t   retired;
  int          mismatch_count;

  assign mismatches = mismatch_count;
  assign awaiting   = due_results.size();

  task automatic move_line(input int unsigned s, input int unsigned src, input int unsigned dst);
    logic [2:0]  st;
    logic [31:0] ad;
    int unsigned r;
    st = state_mem[s][src];
    ad = addr_mem[s][src];
    if (src < dst) begin
      for (r = src; r < dst; r++) begin
        state_mem[s][r] = state_mem[s][r + 1];
        addr_mem[s][r]  = addr_mem[s][r + 1];
      end
    end else begin
      for (r = src; r > dst; r--) begin
        state_mem[s][r] = state_mem[s][r - 1];
        addr_mem[s][r]  = addr_mem[s][r - 1];
      end
    end
    state_mem[s][dst] = st;
    addr_mem[s][dst]  = ad;
  endtask

  task automatic apply_access(input in_item_t acc, output out_item_t rsp);
    int unsigned n;
    int unsigned bits;
    int unsigned s;
    int unsigned r;
    int unsigned rank;
    logic [31:0] blk;
    logic        found;
    logic [2:0]  lru;
    n = (ways_cfg == 0) ? 1 : ((ways_cfg > WAYS) ? WAYS : ways_cfg);
    bits = index_cfg;
    while (bits > 0 && (1 << bits) > MAX_SETS) bits--;
    blk = acc.address >> offset_cfg;
    s = blk & ((32'd1 << bits) - 1);
    lru = state_mem[s][0];
    found = 1'b0;
    rank = 0;
    rsp = '0;
    rsp.line_state = ST_I;
    for (r = 0; r < n; r++) begin
      if (!rsp.hit && state_mem[s][r] != ST_I && (addr_mem[s][r] >> offset_cfg) == blk) begin
        rsp.hit = 1'b1;
        rsp.line_state = state_mem[s][r];
      end
      if (!found && (addr_mem[s][r] >> offset_cfg) == blk) begin
        found = 1'b1;
        rank = r;
      end
    end
    rsp.needs_eviction  = (lru != ST_I);
    rsp.needs_writeback = (lru == ST_M || lru == ST_SM || lru == ST_O);
    rsp.victim_address  = addr_mem[s][0];
    rsp.status = STS_OK;
    case (acc.action)
      ACT_TOUCH: begin
        if (!found) rsp.status = STS_ABSENT;
        else move_line(s, rank, n - 1);
      end
      ACT_INSERT: begin
        if (lru != ST_I) begin
          rsp.status = STS_FULL;
        end else begin
          move_line(s, 0, n - 1);
          state_mem[s][n - 1] = acc.new_state;
          addr_mem[s][n - 1]  = acc.address;
        end
      end
      ACT_UPDATE: begin
        if (!found) rsp.status = STS_ABSENT;
        else state_mem[s][rank] = acc.new_state;
      end
      ACT_REMOVE: begin
        if (!found) begin
          rsp.status = STS_ABSENT;
        end else begin
          state_mem[s][rank] = ST_I;
          move_line(s, rank, 0);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      offset_cfg = 4'd5;
      index_cfg  = 4'd6;
      ways_cfg   = 3'd2;
      for (int s = 0; s < MAX_SETS; s++) begin
        for (int w = 0; w < WAYS; w++) begin
          state_mem[s][w] = ST_I;
          addr_mem[s][w]  = '0;
        end
      end
      due_results.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result beat with none expected, expected nothing, actual 0x%0h",
                   $time, out_data);
        end else begin
          retired = due_results.pop_front();
          check_field("hit", retired.hit, out_data.hit);
          check_field("line_state", retired.line_state, out_data.line_state);
          check_field("needs_eviction", retired.needs_eviction, out_data.needs_eviction);
          check_field("needs_writeback", retired.needs_writeback, out_data.needs_writeback);
          check_field("victim_address", retired.victim_address, out_data.victim_address);
          check_field("status", retired.status, out_data.status);
        end
      end
      if (in_valid && !in_stall) begin
        apply_access(in_data, predicted);
        due_results = {due_results, predicted};
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_BOB: offset_cfg = pwdata[3:0];
          REG_SIB: index_cfg  = pwdata[3:0];
          REG_WIU: ways_cfg   = pwdata[2:0];
          default: ;
        endcase
      end
    end
  end

endmodule

@@ tb/tb.sv @@
// Top of the cache tag and state store test: clock, reset, stimulus, register phases and verdict.
`timescale 1ns / 1ps

module tb;
  import salsc_pkg::*;

  localparam int          MAX_SETS    = 1024;
  localparam int          WAYS        = 4;
  localparam int          IDLE_LIMIT  = 4000;
  localparam int          PHASES      = 8;
  localparam int          PHASE_ITEMS = 204;
  localparam int          POOL_DEPTH  = 12;
  localparam logic [2:0]  ST_S        = 3'd1;
  localparam logic [2:0]  ST_E        = 3'd2;
  localparam logic [2:0]  ST_SC       = 3'd5;
  localparam logic [2:0]  ST_RSV      = 3'd7;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        calm      = 1'b0;
  int          mismatches;
  int          awaiting;
  int          sent_count = 0;
  int unsigned cur_offset = 5;
  logic [31:0] recent_blocks [$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  set_assoc_cache_lru_state_store_core #(
    .MAX_SETS (MAX_SETS),
    .WAYS     (WAYS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  cache_store_checker #(
    .MAX_SETS (MAX_SETS),
    .WAYS     (WAYS)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 32);
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Timeout: no beat for %0d cycles", IDLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_access(input logic [2:0] act, input logic [31:0] addr,
                             input logic [2:0] st);
    int unsigned gap;
    in_item_t    item;
    gap = 0;
    if (!calm) while ($urandom_range(99) < 32) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.action    = act;
    item.address   = addr;
    item.new_state = st;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!(in_valid === 1'b1 && in_stall === 1'b0));
    sent_count++;
    if (act == ACT_INSERT) begin
      recent_blocks = {recent_blocks, addr};
      if (recent_blocks.size() > POOL_DEPTH) void'(recent_blocks.pop_front());
    end
  endtask

  function automatic logic [31:0] pick_address();
    logic [31:0] a;
    if (recent_blocks.size() > 0 && $urandom_range(99) < 70) begin
      a = recent_blocks[$urandom_range(recent_blocks.size() - 1)];
      a = a ^ ($urandom & ((32'd1 << cur_offset) - 1));
    end else begin
      a = $urandom;
    end
    return a;
  endfunction

  function automatic logic [2:0] pick_action();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 18) return ACT_LOOKUP;
    if (r < 33) return ACT_TOUCH;
    if (r < 58) return ACT_INSERT;
    if (r < 73) return ACT_UPDATE;
    if (r < 95) return ACT_REMOVE;
    return ACT_REMOVE + 3'($urandom_range(1, 3));
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (awaiting != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [3:0] phase_offset [PHASES];
    logic [3:0] phase_index  [PHASES];
    logic [2:0] phase_ways   [PHASES];
    int         p;
    int         k;
    phase_offset = '{4'd0, 4'd12, 4'd15, 4'd5, 4'd2, 4'd8, 4'd1, 4'd0};
    phase_index  = '{4'd0, 4'd10, 4'd15, 4'd6, 4'd3, 4'd11, 4'd1, 4'd0};
    phase_ways   = '{3'd1, 3'd4, 3'd7, 3'd0, 3'd3, 3'd4, 3'd2, 3'd1};
    phase_offset[PHASES - 1] = 4'($urandom_range(15));
    phase_index[PHASES - 1]  = 4'($urandom_range(15));
    phase_ways[PHASES - 1]   = 3'($urandom_range(7));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values: 32-byte blocks, 64 sets, two ways
    send_access(ACT_LOOKUP, 32'h0000_0000, ST_I);
    send_access(ACT_TOUCH,  32'h0000_0000, ST_I);
    send_access(ACT_UPDATE, 32'h0000_0000, ST_M);
    send_access(ACT_LOOKUP, 32'h0000_001F, ST_I);
    send_access(ACT_INSERT, 32'h0000_0000, ST_E);
    send_access(ACT_REMOVE, 32'h0000_0010, ST_I);
    send_access(ACT_INSERT, 32'hFFFF_FFFF, ST_SM);
    send_access(ACT_INSERT, 32'hFFFF_FFE0, ST_RSV);
    send_access(ACT_LOOKUP, 32'hFFFF_FFFF, ST_I);
    send_access(ACT_INSERT, 32'h0000_07E0, ST_S);
    send_access(ACT_TOUCH,  32'h1234_5678, ST_I);
    send_access(ACT_UPDATE, 32'hDEAD_BEE0, ST_O);
    send_access(ACT_REMOVE, 32'hCAFE_BABE, ST_I);
    send_access(ACT_REMOVE + 3'd1, 32'hFFFF_FFFF, ST_RSV);
    send_access(ACT_REMOVE + 3'd2, 32'h5555_5555, ST_SC);
    send_access(ACT_REMOVE + 3'd3, 32'hAAAA_AAAA, ST_E);
    send_access(ACT_UPDATE, 32'hFFFF_FFFF, ST_O);
    send_access(ACT_LOOKUP, 32'h0000_07E0, ST_I);
    send_access(ACT_REMOVE, 32'hFFFF_FFE0, ST_I);
    send_access(ACT_INSERT, 32'h8000_0000, ST_I);
    send_access(ACT_LOOKUP, 32'h8000_0000, ST_I);
    send_access(ACT_TOUCH,  32'h8000_0000, ST_I);
    send_access(ACT_UPDATE, 32'h8000_0000, ST_SC);
    send_access(ACT_LOOKUP, 32'h8000_0000, ST_I);

    for (p = 0; p < PHASES; p++) begin
      drain();
      write_reg(REG_BOB, {28'd0, phase_offset[p]});
      write_reg(REG_SIB, {28'd0, phase_index[p]});
      write_reg(REG_WIU, {29'd0, phase_ways[p]});
      cur_offset = phase_offset[p];
      calm <= (p == 3);
      for (k = 0; k < PHASE_ITEMS; k++)
        send_access(pick_action(), pick_address(), 3'($urandom_range(7)));
    end

    drain();
    calm <= 1'b0;
    repeat (20) @(posedge clk);
    $display("Ran %0d accesses: directed corner cases, then %0d register settings", sent_count,
             PHASES);
    $display("with offsets 0..15, set bits 0..15 and way counts 0..7, under random stalls.");
    if (awaiting != 0) $display("%0d expected results never arrived", awaiting);
    if (mismatches == 0 && awaiting == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/salsc_pkg.sv
hw/rtl/salsc_ram.sv
hw/rtl/salsc_scan.sv
hw/rtl/salsc_upd.sv
hw/rtl/set_assoc_cache_lru_state_store_core.sv
tb/cache_store_checker.sv
tb/tb.sv
